[src/upc_pkg.sv]
// Package: shared types, character constants and helper functions for the percent codec.
`timescale 1ns / 1ps

package upc_pkg;

    localparam int unsigned RES_MAX = 4;        // results one input transaction can cause
    localparam int unsigned CH_MAX  = 3;        // characters one input transaction can cause

    localparam logic [11:0] LIMIT_RESET = 12'd499;

    localparam logic [7:0] CH_PCT   = 8'h25;    // '%'
    localparam logic [7:0] CH_PLUS  = 8'h2B;    // '+'
    localparam logic [7:0] CH_SPACE = 8'h20;    // ' '
    localparam logic [7:0] CH_SLASH = 8'h2F;    // '/'
    localparam logic [7:0] CH_BSL   = 8'h5C;    // '\'

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,    // nothing held
        PEND_PCT   = 3'b010,    // '%' held
        PEND_DIGIT = 3'b100     // '%' and one hex digit held
    } pend_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
        logic       string_end;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_terminator;
        logic [11:0] out_length;
        logic        truncated;
        logic        last;
    } out_t;

    typedef struct packed {
        pend_t       pend;
        logic [7:0]  digit;
        logic [11:0] produced;
        logic        stopped;
    } state_t;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                 (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Nibble value of a hex digit of either case; zero for anything else.
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            hex_val = b[3:0];
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            hex_val = b[3:0] + 4'd9;
        else
            hex_val = 4'd0;
    endfunction

    // Uppercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            hex_char = 8'h30 + {4'd0, v};
        else
            hex_char = 8'h37 + {4'd0, v};
    endfunction

    function automatic logic passes(input logic [7:0] b);
        passes = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h30 && b <= 8'h39) || b == CH_SLASH || b == CH_BSL;
    endfunction

endpackage

[src/upc_step.sv]
// Per-transaction step: builds the result list and the next codec state in one pass.
`timescale 1ns / 1ps

module upc_step (
    input  upc_pkg::in_t                          item,
    input  upc_pkg::state_t                       cur,
    input  logic [11:0]                           limit,
    output upc_pkg::state_t                       nxt,
    output upc_pkg::out_t [upc_pkg::RES_MAX-1:0]  res,
    output logic [2:0]                            res_cnt
);
    import upc_pkg::*;

    logic [7:0]  ch [0:CH_MAX-1];
    logic [1:0]  n;
    logic        triple;
    logic        plain_go;
    pend_t       pend_mid;
    logic [7:0]  digit_mid;
    logic [12:0] diff;
    logic [1:0]  room;
    logic [1:0]  emit;
    logic [11:0] prod_pre;
    logic        stop_pre;

    // Candidate characters, in order, before the length limit.
    always_comb
    begin
        for (int i = 0; i < CH_MAX; i++)
        begin
            ch[i] = 8'd0;
        end
        n         = 2'd0;
        triple    = 1'b0;
        plain_go  = 1'b0;
        pend_mid  = cur.pend;
        digit_mid = cur.digit;

        if (!item.req_type)
        begin
            pend_mid  = PEND_NONE;
            digit_mid = 8'd0;
            if (passes(item.in_byte))
            begin
                ch[0] = item.in_byte;
                n     = 2'd1;
            end
            else if (item.in_byte == CH_SPACE)
            begin
                ch[0] = CH_PLUS;
                n     = 2'd1;
            end
            else
            begin
                ch[0]  = CH_PCT;
                ch[1]  = hex_char(item.in_byte[7:4]);
                ch[2]  = hex_char(item.in_byte[3:0]);
                n      = 2'd3;
                triple = 1'b1;
            end
        end
        else
        begin
            unique case (cur.pend)
                PEND_PCT:
                begin
                    if (is_hex(item.in_byte))
                    begin
                        pend_mid  = PEND_DIGIT;
                        digit_mid = item.in_byte;
                    end
                    else
                    begin
                        pend_mid = PEND_NONE;
                        ch[0]    = CH_PCT;
                        n        = 2'd1;
                        plain_go = 1'b1;
                    end
                end
                PEND_DIGIT:
                begin
                    pend_mid = PEND_NONE;
                    if (is_hex(item.in_byte))
                    begin
                        ch[0] = {hex_val(cur.digit), hex_val(item.in_byte)};
                        n     = 2'd1;
                    end
                    else
                    begin
                        ch[0]    = CH_PCT;
                        ch[1]    = cur.digit;
                        n        = 2'd2;
                        plain_go = 1'b1;
                    end
                end
                default:
                begin
                    plain_go = 1'b1;
                end
            endcase

            if (plain_go)
            begin
                if (item.in_byte == CH_PCT)
                begin
                    pend_mid = PEND_PCT;
                end
                else
                begin
                    ch[n] = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
                    n     = n + 2'd1;
                end
            end
        end

        // Held sequence at string end goes out literally.
        if (item.string_end)
        begin
            unique case (pend_mid)
                PEND_PCT:
                begin
                    ch[n] = CH_PCT;
                    n     = n + 2'd1;
                end
                PEND_DIGIT:
                begin
                    ch[0] = CH_PCT;
                    ch[1] = digit_mid;
                    n     = 2'd2;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Length limit: singles go out while room lasts, a %XY triple all or nothing.
    always_comb
    begin
        diff = {1'b0, limit} - {1'b0, cur.produced};
        if (cur.stopped || diff[12])
            room = 2'd0;
        else if (diff[11:2] != 10'd0)
            room = 2'd3;
        else
            room = diff[1:0];

        if (triple)
            emit = (room == 2'd3) ? 2'd3 : 2'd0;
        else
            emit = (n < room) ? n : room;

        prod_pre = cur.produced + {10'd0, emit};
        stop_pre = cur.stopped | (emit < n);
    end

    always_comb
    begin
        res = '0;
        for (int i = 0; i < CH_MAX; i++)
        begin
            if (2'(i) < emit)
                res[i].out_byte = ch[i];
        end
        if (item.string_end)
        begin
            res[emit].is_terminator = 1'b1;
            res[emit].out_length    = prod_pre;
            res[emit].truncated     = stop_pre;
        end
        res_cnt = {1'b0, emit} + {2'd0, item.string_end};
        for (int i = 0; i < RES_MAX; i++)
        begin
            res[i].last = (3'(i) == res_cnt - 3'd1);
        end

        if (item.string_end)
        begin
            nxt.pend     = PEND_NONE;
            nxt.digit    = 8'd0;
            nxt.produced = 12'd0;
            nxt.stopped  = 1'b0;
        end
        else
        begin
            nxt.pend     = pend_mid;
            nxt.digit    = digit_mid;
            nxt.produced = prod_pre;
            nxt.stopped  = stop_pre;
        end
    end

endmodule

[src/url_percent_codec_top.sv]
// Top level: streaming URL percent encoder / decoder with length limit.
`timescale 1ns / 1ps

// Usage
//   in_*  : one string byte per transaction (req_type, in_byte, string_end).
//           Accepted when in_valid is high and in_stall is low.
//   out_* : result transactions, in order, one per cycle while out_stall
//           is low. Each input causes 0 to 4 results; the last one carries
//           last = 1. The byte flagged string_end is followed by a
//           terminator result with out_length and truncated.
//   cfg_* : out_limit write; cfg_ready is always high. Write only while idle.
// Path: an accepted input goes through the input register, then the result
//   buffer, before its first result is on out_*.
// Throughput: one input per cycle when out_stall is low and each input
//   causes at most one result; an input causing more results holds the
//   next one while the result buffer drains one result per cycle.
// Reset: out_limit returns to 499, all codec state and both stages clear.
// Stall: out_stall freezes the result buffer; the input register still
//   takes one more transaction, then in_stall rises until the buffer frees.

module url_percent_codec_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  upc_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output upc_pkg::out_t   out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [11:0]     cfg_data
);
    import upc_pkg::*;

    // Configuration
    logic [11:0] limit_reg;

    // Input register stage
    logic        in_vld_reg, in_vld_next;
    in_t         in_item_reg;

    // Codec state carried between transactions of one string
    state_t      state_reg;
    state_t      state_next;

    // Result buffer: entry 0 is on the output, shifts down on each pop
    out_t [RES_MAX-1:0] buf_reg, buf_next;
    logic [2:0]         buf_cnt_reg, buf_cnt_next;

    out_t [RES_MAX-1:0] step_res;
    logic [2:0]         step_cnt;

    logic pop;
    logic buf_free;
    logic load;
    logic accept;

    assign cfg_ready = 1'b1;

    assign out_valid = (buf_cnt_reg != 3'd0);
    assign out_data  = buf_reg[0];
    assign pop       = out_valid && !out_stall;

    // Buffer can take a new result list this cycle
    assign buf_free  = (buf_cnt_reg == 3'd0) || (pop && buf_cnt_reg == 3'd1);
    assign load      = in_vld_reg && buf_free;
    assign in_stall  = in_vld_reg && !buf_free;
    assign accept    = in_valid && !in_stall;

    upc_step u_step (
        .item    (in_item_reg),
        .cur     (state_reg),
        .limit   (limit_reg),
        .nxt     (state_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (load)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_comb
    begin
        buf_next     = buf_reg;
        buf_cnt_next = buf_cnt_reg;
        if (load)
        begin
            buf_next     = step_res;
            buf_cnt_next = step_cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < RES_MAX - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[RES_MAX-1] = '0;
            buf_cnt_next        = buf_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg            <= LIMIT_RESET;
            in_vld_reg           <= 1'b0;
            buf_cnt_reg          <= 3'd0;
            state_reg.pend       <= PEND_NONE;
            state_reg.digit      <= 8'd0;
            state_reg.produced   <= 12'd0;
            state_reg.stopped    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            in_vld_reg  <= in_vld_next;
            buf_cnt_reg <= buf_cnt_next;
            if (load)
                state_reg <= state_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        buf_reg <= buf_next;
    end

    // Buffer never holds more than one transaction's worth of results
    a_buf_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'(RES_MAX))
        else $error("result buffer count out of range");

    // A terminator is always the final result of its input
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_terminator |-> out_data.last)
        else $error("terminator not marked last");

    // Length and truncation only appear on a terminator
    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_terminator |->
            out_data.out_length == 12'd0 && !out_data.truncated)
        else $error("length fields set on a character result");

    // Input side stalls only with a full input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    // A consumed last result with nothing loaded leaves the buffer empty
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && out_data.last && !load |=> !out_valid)
        else $error("results remain after last");

endmodule
